// ===== hdl/bfpf_pkg.sv =====
// shared types, constants and codes for the box filter peak finder
package bfpf_pkg;

  // default sizing of the top level
  localparam int DEF_MAX_WIDTH    = 1024;
  localparam int DEF_MAX_HEIGHT   = 1024;
  localparam int DEF_MAX_FILTER_W = 64;
  localparam int DEF_MAX_FILTER_H = 64;
  localparam int DEF_VALUE_BITS   = 16;

  // fixed field widths
  localparam int PIXEL_W    = 16;
  localparam int POS_W      = 10;
  localparam int VAL_W      = 28;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  // register values after reset, before clamping
  localparam int DIM_RESET    = 1024;
  localparam int FILTER_RESET = 3;

  // result queue: depth and the room kept for items still in the pipeline
  localparam int FIFO_DEPTH   = 16;
  localparam int FIFO_RESERVE = 8;

  localparam logic [VAL_W-1:0] SUM_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_HEIGHT = 2'd3;

  typedef enum logic [1:0] {
    KIND_SUM   = 2'd0,
    KIND_PEAK  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // one result item
  typedef struct packed {
    kind_t              kind;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [VAL_W-1:0]   value;
    logic               last;
  } res_t;

  // window stage to peak tracker
  typedef struct packed {
    logic               valid;
    logic               emit;
    logic               frame_end;
    logic               too_big;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [VAL_W-1:0]   sum;
  } win_t;

  // up to two result items pushed into the queue in one cycle
  typedef struct packed {
    logic [1:0]         count;
    res_t               res_a;
    res_t               res_b;
  } push_t;

endpackage

// ===== hdl/bfpf_fifo.sv =====
// result queue taking up to two items a cycle and giving one
module bfpf_fifo (
  input  logic              clk,
  input  logic              rst,
  input  bfpf_pkg::push_t   push,
  input  logic              pop,
  output logic              valid,
  output bfpf_pkg::res_t    head,
  output logic              room
);
  import bfpf_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  res_t             entries [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  // storage, second item goes to the following slot
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.res_a;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr + PTR_W'(1)] <= push.res_b;
    end
  end

  assign valid = (count != '0);
  assign head  = entries[rd_ptr];
  assign room  = (count <= CNT_W'(FIFO_DEPTH - FIFO_RESERVE));

endmodule

// ===== hdl/bfpf_window.sv =====
// frame position, line memories and box sum pipeline
module bfpf_window #(
  parameter int MAX_WIDTH    = bfpf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = bfpf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_FILTER_W = bfpf_pkg::DEF_MAX_FILTER_W,
  parameter int MAX_FILTER_H = bfpf_pkg::DEF_MAX_FILTER_H,
  parameter int VALUE_BITS   = bfpf_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                restart,
  input  logic                                accept,
  input  logic [bfpf_pkg::PIXEL_W-1:0]        pixel_value,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      img_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     img_h,
  input  logic [$clog2(MAX_FILTER_W+1)-1:0]   flt_w,
  input  logic [$clog2(MAX_FILTER_H+1)-1:0]   flt_h,
  output bfpf_pkg::win_t                      win
);
  import bfpf_pkg::*;

  localparam int PIX_W  = (VALUE_BITS < PIXEL_W) ? VALUE_BITS : PIXEL_W;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int PS_W   = (MAX_FILTER_W > 1) ? $clog2(MAX_FILTER_W) : 1;
  localparam int HS_W   = (MAX_FILTER_H > 1) ? $clog2(MAX_FILTER_H) : 1;
  localparam int HSUM_W = PIX_W + $clog2(MAX_FILTER_W + 1);
  localparam int CSUM_W = HSUM_W + $clog2(MAX_FILTER_H + 1);
  localparam int SAT_W  = (CSUM_W > VAL_W) ? CSUM_W : VAL_W;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic [HS_W-1:0]  hslot;
    logic [HS_W-1:0]  rd_hslot;
    logic             first_col;
    logic             sub_pix;
    logic             first_row;
    logic             sub_row;
    logic             emit;
    logic             frame_end;
    logic             too_big;
    logic [POS_W-1:0] trow;
    logic [POS_W-1:0] tcol;
  } stage_t;

  // frame position
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [PS_W-1:0]  pslot;
  logic [HS_W-1:0]  hslot;
  logic [PS_W-1:0]  pslot_inc;
  logic [HS_W-1:0]  hslot_inc;
  logic [PS_W-1:0]  rd_pslot;
  logic             too_big;
  logic             row_end;
  logic             frame_end;
  logic [31:0]      tr32;
  logic [31:0]      tc32;
  logic [31:0]      ps32;
  logic [31:0]      hs32;
  stage_t           stage_a;

  // memories
  logic [PIX_W-1:0]  recent_mem [MAX_FILTER_W];
  logic [HSUM_W-1:0] hist_mem   [MAX_FILTER_H][MAX_WIDTH];
  logic [CSUM_W-1:0] col_mem    [MAX_WIDTH];

  // pipeline
  logic              b_valid;
  stage_t            stg_b;
  logic [PIX_W-1:0]  rp_rd;
  logic [HSUM_W-1:0] rs_reg;
  logic [HSUM_W:0]   rs_wide;
  logic [HSUM_W-1:0] rs_b;

  logic              c_valid;
  stage_t            stg_c;
  logic [HSUM_W-1:0] rs_c;
  logic [HSUM_W-1:0] hist_rd;
  logic [CSUM_W-1:0] col_rd;
  logic              hist_fwd;
  logic              col_fwd;
  logic [HSUM_W-1:0] hist_fwd_data;
  logic [CSUM_W-1:0] col_fwd_data;
  logic [HSUM_W-1:0] hist_src;
  logic [CSUM_W-1:0] col_src;
  logic [CSUM_W:0]   col_wide;
  logic [CSUM_W-1:0] colsum_c;

  logic              d_valid;
  stage_t            stg_d;
  logic [CSUM_W-1:0] colsum_d;
  logic [SAT_W-1:0]  sat_wide;

  // position decode and read slots for the incoming item
  always_comb begin
    too_big   = (32'(flt_w) > 32'(img_w)) || (32'(flt_h) > 32'(img_h));
    row_end   = (32'(col) + 32'd1) == 32'(img_w);
    frame_end = row_end && ((32'(row) + 32'd1) == 32'(img_h));
    tr32      = 32'(row) + 32'd1 - 32'(flt_h);
    tc32      = 32'(col) + 32'd1 - 32'(flt_w);

    // slot of the value that leaves the row window
    ps32 = 32'(pslot) + 32'(MAX_FILTER_W) - 32'(flt_w);
    if (ps32 >= 32'(MAX_FILTER_W)) begin
      ps32 = ps32 - 32'(MAX_FILTER_W);
    end
    rd_pslot = ps32[PS_W-1:0];

    // slot of the row sum that leaves the column window
    hs32 = 32'(hslot) + 32'(MAX_FILTER_H) - 32'(flt_h);
    if (hs32 >= 32'(MAX_FILTER_H)) begin
      hs32 = hs32 - 32'(MAX_FILTER_H);
    end

    pslot_inc = (32'(pslot) == 32'(MAX_FILTER_W - 1)) ? '0 : pslot + PS_W'(1);
    hslot_inc = (32'(hslot) == 32'(MAX_FILTER_H - 1)) ? '0 : hslot + HS_W'(1);

    stage_a.pix       = pixel_value[PIX_W-1:0];
    stage_a.col       = col;
    stage_a.hslot     = hslot;
    stage_a.rd_hslot  = hs32[HS_W-1:0];
    stage_a.first_col = (col == '0);
    stage_a.sub_pix   = 32'(col) >= 32'(flt_w);
    stage_a.first_row = (row == '0);
    stage_a.sub_row   = 32'(row) >= 32'(flt_h);
    stage_a.emit      = !too_big && ((32'(row) + 32'd1) >= 32'(flt_h))
                        && ((32'(col) + 32'd1) >= 32'(flt_w));
    stage_a.frame_end = frame_end;
    stage_a.too_big   = too_big;
    stage_a.trow      = tr32[POS_W-1:0];
    stage_a.tcol      = tc32[POS_W-1:0];
  end

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row   <= '0;
      col   <= '0;
      pslot <= '0;
      hslot <= '0;
    end else if (accept) begin
      if (frame_end) begin
        row   <= '0;
        col   <= '0;
        pslot <= '0;
        hslot <= '0;
      end else if (row_end) begin
        row   <= row + ROW_W'(1);
        col   <= '0;
        pslot <= '0;
        hslot <= hslot_inc;
      end else begin
        col   <= col + COL_W'(1);
        pslot <= pslot_inc;
      end
    end
  end

  // recent values of the current row, old data on a same-slot read
  always_ff @(posedge clk) begin
    if (accept) begin
      recent_mem[pslot] <= stage_a.pix;
      rp_rd             <= recent_mem[rd_pslot];
    end
  end

  // stage b: horizontal sum
  always_comb begin
    rs_wide = (stg_b.first_col ? '0 : {1'b0, rs_reg})
              + (HSUM_W+1)'(stg_b.pix)
              - (stg_b.sub_pix ? (HSUM_W+1)'(rp_rd) : '0);
    rs_b    = rs_wide[HSUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      b_valid <= accept;
      c_valid <= b_valid;
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      rs_reg <= '0;
    end else if (b_valid) begin
      rs_reg <= rs_b;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_b <= stage_a;
    end
    if (b_valid) begin
      stg_c <= stg_b;
      rs_c  <= rs_b;
    end
    if (c_valid) begin
      stg_d    <= stg_c;
      colsum_d <= colsum_c;
    end
  end

  // row sum history: read for stage c, written as stage c leaves
  always_ff @(posedge clk) begin
    if (b_valid) begin
      hist_rd <= hist_mem[stg_b.rd_hslot][stg_b.col];
    end
    if (c_valid) begin
      hist_mem[stg_c.hslot][stg_c.col] <= rs_c;
    end
  end

  // column sums: read for stage c, written as stage c leaves
  always_ff @(posedge clk) begin
    if (b_valid) begin
      col_rd <= col_mem[stg_b.col];
    end
    if (c_valid) begin
      col_mem[stg_c.col] <= colsum_c;
    end
  end

  // forwarding when the read meets the write of the item ahead
  always_ff @(posedge clk) begin
    if (b_valid) begin
      hist_fwd      <= c_valid && (stg_c.hslot == stg_b.rd_hslot) && (stg_c.col == stg_b.col);
      col_fwd       <= c_valid && (stg_c.col == stg_b.col);
      hist_fwd_data <= rs_c;
      col_fwd_data  <= colsum_c;
    end
  end

  // stage c: vertical sum, first row starts from zero
  always_comb begin
    hist_src = hist_fwd ? hist_fwd_data : hist_rd;
    col_src  = col_fwd ? col_fwd_data : col_rd;
    col_wide = (stg_c.first_row ? '0 : {1'b0, col_src})
               + (CSUM_W+1)'(rs_c)
               - (stg_c.sub_row ? (CSUM_W+1)'(hist_src) : '0);
    colsum_c = col_wide[CSUM_W-1:0];
  end

  // stage d: saturated sum out
  always_comb begin
    sat_wide      = SAT_W'(colsum_d);
    win.valid     = d_valid;
    win.emit      = stg_d.emit;
    win.frame_end = stg_d.frame_end;
    win.too_big   = stg_d.too_big;
    win.row       = stg_d.trow;
    win.col       = stg_d.tcol;
    win.sum       = (sat_wide > SAT_W'(SUM_MAX)) ? SUM_MAX : sat_wide[VAL_W-1:0];
  end

endmodule

// ===== hdl/bfpf_report.sv =====
// peak tracking and assembly of result items
module bfpf_report (
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  bfpf_pkg::win_t    win,
  output bfpf_pkg::push_t   push
);
  import bfpf_pkg::*;

  logic [VAL_W-1:0] peak_sum;
  logic [POS_W-1:0] peak_row;
  logic [POS_W-1:0] peak_col;
  logic             better;
  logic [VAL_W-1:0] peak_sum_next;
  logic [POS_W-1:0] peak_row_next;
  logic [POS_W-1:0] peak_col_next;
  res_t             sum_res;
  res_t             end_res;

  // strictly larger sums only, so the first peak in raster order stays
  always_comb begin
    better        = win.valid && win.emit && (win.sum > peak_sum);
    peak_sum_next = better ? win.sum : peak_sum;
    peak_row_next = better ? win.row : peak_row;
    peak_col_next = better ? win.col : peak_col;
  end

  // result items for this window
  always_comb begin
    sum_res.kind  = KIND_SUM;
    sum_res.row   = win.row;
    sum_res.col   = win.col;
    sum_res.value = win.sum;
    sum_res.last  = 1'b0;

    if (win.too_big) begin
      end_res.kind  = KIND_ERROR;
      end_res.row   = '0;
      end_res.col   = '0;
      end_res.value = '0;
    end else begin
      end_res.kind  = KIND_PEAK;
      end_res.row   = peak_row_next;
      end_res.col   = peak_col_next;
      end_res.value = peak_sum_next;
    end
    end_res.last = 1'b1;

    push.count = win.valid ? ({1'b0, win.emit} + {1'b0, win.frame_end}) : 2'd0;
    push.res_a = win.emit ? sum_res : end_res;
    push.res_b = end_res;
  end

  // peak registers, cleared at frame end and on a register write
  always_ff @(posedge clk) begin
    if (rst || restart || (win.valid && win.frame_end)) begin
      peak_sum <= '0;
      peak_row <= '0;
      peak_col <= '0;
    end else begin
      peak_sum <= peak_sum_next;
      peak_row <= peak_row_next;
      peak_col <= peak_col_next;
    end
  end

endmodule

// ===== hdl/box_filter_peak_finder_core.sv =====
// top level of the streaming box filter with peak search
//
// Map values enter on in_valid / in_stall / pixel_value in raster order;
// the block counts rows and columns itself. For each box that lies
// wholly inside the frame, one item (kind sum) leaves on out_valid /
// out_stall with the box's top row and left column as soon as its
// bottom-right value is in. With the frame's last value a final item
// follows: the first largest sum and its position (kind peak), or, when
// the box is larger than the frame, one error item; last marks it.
// Throughput is one value per cycle while in_stall is low. An accepted
// value passes a recent-value read, the row-history and column-sum memory
// reads, the read-modify-write of those memories and a saturation stage
// in that order, then its results enter the queue. Back-to-back accesses
// to the same memory entry are forwarded. Results wait in a sixteen-item
// queue; in_stall rises while it holds more than eight, so a stalled
// receiver backs up into the source with nothing lost. Reset and any
// register write restart the frame at row 0, column 0 and clear the peak;
// the user must write registers only while idle; nothing enforces it.
module box_filter_peak_finder_core #(
  parameter int MAX_WIDTH    = bfpf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = bfpf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_FILTER_W = bfpf_pkg::DEF_MAX_FILTER_W,
  parameter int MAX_FILTER_H = bfpf_pkg::DEF_MAX_FILTER_H,
  parameter int VALUE_BITS   = bfpf_pkg::DEF_VALUE_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bfpf_pkg::PIXEL_W-1:0]      pixel_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        kind,
  output logic [bfpf_pkg::POS_W-1:0]        out_row,
  output logic [bfpf_pkg::POS_W-1:0]        out_col,
  output logic [bfpf_pkg::VAL_W-1:0]        value,
  output logic                              last,
  input  logic                              cfg_write,
  input  logic [bfpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bfpf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bfpf_pkg::*;

  localparam int WD_W = $clog2(MAX_WIDTH + 1);
  localparam int HD_W = $clog2(MAX_HEIGHT + 1);
  localparam int FW_W = $clog2(MAX_FILTER_W + 1);
  localparam int FH_W = $clog2(MAX_FILTER_H + 1);

  localparam int W_RST  = (DIM_RESET < MAX_WIDTH) ? DIM_RESET : MAX_WIDTH;
  localparam int H_RST  = (DIM_RESET < MAX_HEIGHT) ? DIM_RESET : MAX_HEIGHT;
  localparam int FW_RST = (FILTER_RESET < MAX_FILTER_W) ? FILTER_RESET : MAX_FILTER_W;
  localparam int FH_RST = (FILTER_RESET < MAX_FILTER_H) ? FILTER_RESET : MAX_FILTER_H;

  logic [WD_W-1:0] img_w;
  logic [HD_W-1:0] img_h;
  logic [FW_W-1:0] flt_w;
  logic [FH_W-1:0] flt_h;
  logic [31:0]     data32;
  logic [31:0]     flt32;
  logic [31:0]     w_clamp;
  logic [31:0]     h_clamp;
  logic [31:0]     fw_clamp;
  logic [31:0]     fh_clamp;

  logic    accept;
  logic    room;
  win_t    win;
  push_t   push;
  res_t    head;

  // registers hold the clamped dimension, box sizes keep seven bits
  always_comb begin
    data32   = 32'(cfg_data);
    flt32    = 32'(cfg_data[6:0]);
    w_clamp  = (data32 == 32'd0) ? 32'd1 :
               ((data32 > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : data32);
    h_clamp  = (data32 == 32'd0) ? 32'd1 :
               ((data32 > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : data32);
    fw_clamp = (flt32 == 32'd0) ? 32'd1 :
               ((flt32 > 32'(MAX_FILTER_W)) ? 32'(MAX_FILTER_W) : flt32);
    fh_clamp = (flt32 == 32'd0) ? 32'd1 :
               ((flt32 > 32'(MAX_FILTER_H)) ? 32'(MAX_FILTER_H) : flt32);
  end

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w <= WD_W'(W_RST);
      img_h <= HD_W'(H_RST);
      flt_w <= FW_W'(FW_RST);
      flt_h <= FH_W'(FH_RST);
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   img_w <= w_clamp[WD_W-1:0];
        CFG_IMAGE_HEIGHT:  img_h <= h_clamp[HD_W-1:0];
        CFG_FILTER_WIDTH:  flt_w <= fw_clamp[FW_W-1:0];
        CFG_FILTER_HEIGHT: flt_h <= fh_clamp[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // input handshake held back by queue room
  assign in_stall = !room;
  assign accept   = in_valid && !in_stall;

  bfpf_window #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_FILTER_W (MAX_FILTER_W),
    .MAX_FILTER_H (MAX_FILTER_H),
    .VALUE_BITS   (VALUE_BITS)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .restart     (cfg_write),
    .accept      (accept),
    .pixel_value (pixel_value),
    .img_w       (img_w),
    .img_h       (img_h),
    .flt_w       (flt_w),
    .flt_h       (flt_h),
    .win         (win)
  );

  bfpf_report u_report (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_write),
    .win     (win),
    .push    (push)
  );

  bfpf_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (out_valid && !out_stall),
    .valid (out_valid),
    .head  (head),
    .room  (room)
  );

  // result item fields
  assign kind    = head.kind;
  assign out_row = head.row;
  assign out_col = head.col;
  assign value   = head.value;
  assign last    = head.last;

endmodule

// ===== tb/box_filter_peak_finder_core_tb.sv =====
// self-checking testbench for the streaming box filter with peak search
`timescale 1ns / 1ps

module box_filter_peak_finder_core_tb;
  import bfpf_pkg::*;

  // cycles left for values still in the pipeline before a register write
  localparam int PIPE_SETTLE    = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RING_ROWS      = DEF_MAX_FILTER_H;

  typedef enum int unsigned {PIX_RANDOM, PIX_SMALL, PIX_RAILS, PIX_FLAT} pixel_style_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIXEL_W-1:0]    pixel_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            kind;
  logic [POS_W-1:0]      out_row;
  logic [POS_W-1:0]      out_col;
  logic [VAL_W-1:0]      value;
  logic                  last;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shared run state
  res_t results_due [$];
  bit   idle_gaps = 1'b1;
  bit   stall_bursts = 1'b1;
  int   stall_hold = 0;
  int   quiet_cycles = 0;
  int   fail_count = 0;
  int   pixels_sent = 0;
  int   results_seen = 0;
  int   settings_used = 0;

  // predictor state: registers as written, frame position, peak, recent rows
  logic [10:0]        reg_img_w, reg_img_h;
  logic [6:0]         reg_flt_w, reg_flt_h;
  int unsigned        frame_row, frame_col;
  logic [VAL_W-1:0]   best_sum;
  int unsigned        best_row, best_col;
  logic [PIXEL_W-1:0] pixel_store [0:RING_ROWS-1][0:DEF_MAX_WIDTH-1];

  box_filter_peak_finder_core uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel_value (pixel_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .out_row     (out_row),
    .out_col     (out_col),
    .value       (value),
    .last        (last),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    frame_row = 0;
    frame_col = 0;
    best_sum  = '0;
    best_row  = 0;
    best_col  = 0;
  endfunction

  function automatic void reset_predictor();
    reg_img_w = 11'(DIM_RESET);
    reg_img_h = 11'(DIM_RESET);
    reg_flt_w = 7'(FILTER_RESET);
    reg_flt_h = 7'(FILTER_RESET);
    restart_frame();
  endfunction

  function automatic void store_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IMAGE_WIDTH:   reg_img_w = data;
      CFG_IMAGE_HEIGHT:  reg_img_h = data;
      CFG_FILTER_WIDTH:  reg_flt_w = data[6:0];
      CFG_FILTER_HEIGHT: reg_flt_h = data[6:0];
      default: ;
    endcase
    restart_frame();
  endfunction

  // works out the box sum and frame-end results caused by one map value
  function automatic void predict_box_outputs(input logic [PIXEL_W-1:0] pix);
    int unsigned w, h, fw, fh, r, c, top, left;
    longint unsigned acc;
    bit too_big;
    res_t item;
    w  = clamp_dim(reg_img_w, DEF_MAX_WIDTH);
    h  = clamp_dim(reg_img_h, DEF_MAX_HEIGHT);
    fw = clamp_dim(reg_flt_w, DEF_MAX_FILTER_W);
    fh = clamp_dim(reg_flt_h, DEF_MAX_FILTER_H);
    too_big = (fw > w) || (fh > h);
    r = (frame_row >= h) ? 0 : frame_row;
    c = (frame_col >= w) ? 0 : frame_col;

    if (!too_big) begin
      pixel_store[r % RING_ROWS][c] = pix;
      if (r + 1 >= fh && c + 1 >= fw) begin
        top  = r + 1 - fh;
        left = c + 1 - fw;
        acc  = 0;
        for (int unsigned i = top; i <= r; i++)
          for (int unsigned j = left; j <= c; j++)
            acc += pixel_store[i % RING_ROWS][j];
        if (acc > SUM_MAX) acc = SUM_MAX;
        item.kind  = KIND_SUM;
        item.row   = POS_W'(top);
        item.col   = POS_W'(left);
        item.value = VAL_W'(acc);
        item.last  = 1'b0;
        results_due.push_back(item);
        // first largest sum wins, ties keep the earlier window
        if (acc > best_sum) begin
          best_sum = VAL_W'(acc);
          best_row = top;
          best_col = left;
        end
      end
    end

    if (r + 1 == h && c + 1 == w) begin
      item.kind  = too_big ? KIND_ERROR : KIND_PEAK;
      item.row   = too_big ? '0 : POS_W'(best_row);
      item.col   = too_big ? '0 : POS_W'(best_col);
      item.value = too_big ? '0 : best_sum;
      item.last  = 1'b1;
      results_due.push_back(item);
      restart_frame();
    end else if (c + 1 == w) begin
      frame_col = 0;
      frame_row = r + 1;
    end else begin
      frame_col = c + 1;
      frame_row = r;
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // one map value; a random gap may come first
  task automatic send_pixel(input logic [PIXEL_W-1:0] pix);
    int gap;
    @(negedge clk);
    if (idle_gaps && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    pixel_value <= pix;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_box_outputs(pix);
    pixels_sent++;
  endtask

  // stop sending, let every expected result out and the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(negedge clk);
  endtask

  // called at a falling edge; the write lands on the next rising edge
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    store_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic configure(input logic [10:0] w, input logic [10:0] h,
                           input logic [10:0] fw, input logic [10:0] fh,
                           input bit [3:0] pick = 4'hF);
    wait_drained();
    if (pick[CFG_IMAGE_WIDTH])   put_reg(CFG_IMAGE_WIDTH, w);
    if (pick[CFG_IMAGE_HEIGHT])  put_reg(CFG_IMAGE_HEIGHT, h);
    if (pick[CFG_FILTER_WIDTH])  put_reg(CFG_FILTER_WIDTH, fw);
    if (pick[CFG_FILTER_HEIGHT]) put_reg(CFG_FILTER_HEIGHT, fh);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [PIXEL_W-1:0] pick_pixel(input pixel_style_t style,
                                                    input logic [PIXEL_W-1:0] level);
    case (style)
      PIX_RANDOM: return PIXEL_W'($urandom);
      PIX_SMALL:  return PIXEL_W'($urandom_range(0, 15));
      PIX_RAILS:  return $urandom_range(0, 1) ? '1 : '0;
      default:    return ($urandom_range(0, 3) == 0) ? PIXEL_W'($urandom) : level;
    endcase
  endfunction

  // ---------------------------------------------------------------- receiver

  // output stall in random bursts, with free stretches in between
  always @(negedge clk) begin
    if (rst || !stall_bursts) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 18);
    end else begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 12);
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (results_due.size() == 0) begin
        $error("result with nothing expected: kind %0d row %0d col %0d value %0d last %0d",
               kind, out_row, out_col, value, last);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          fail_count++;
        end
        if (out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_row);
          fail_count++;
        end
        if (out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_col);
          fail_count++;
        end
        if (value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, value);
          fail_count++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("no item moved for %0d cycles, %0d results still due",
               WATCHDOG_LIMIT, results_due.size());
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests

  // one box covering the whole frame, all values at full scale
  task automatic test_full_scale_box();
    configure(11'd3, 11'd3, 11'd3, 11'd3);
    repeat (9) send_pixel('1);
  endtask

  // all sums zero: peak reported as zero at the origin
  task automatic test_zero_map();
    configure(11'd2, 11'd2, 11'd1, 11'd1);
    repeat (4) send_pixel('0);
  endtask

  // equal sums along a row: the first one stays the peak
  task automatic test_tied_peaks();
    configure(11'd4, 11'd1, 11'd2, 11'd1);
    send_pixel(16'd3);
    send_pixel(16'd4);
    send_pixel(16'd3);
    send_pixel(16'd4);
  endtask

  // box wider than the frame: only the error item at frame end
  task automatic test_box_exceeds_frame();
    configure(11'd2, 11'd2, 11'd3, 11'd2);
    repeat (4) send_pixel(PIXEL_W'($urandom));
  endtask

  // zero and masked-to-zero writes clamp to one: sum and peak per value
  task automatic test_register_clamping();
    configure(11'd0, 11'd0, 11'd0, 11'd128);
    send_pixel(16'h8001);
    send_pixel(16'h7FFE);
  endtask

  // largest sizes and over-range writes, kept short
  task automatic test_dimension_extremes();
    configure(11'd1024, 11'd1024, 11'd64, 11'd64);
    repeat (10) send_pixel(PIXEL_W'($urandom));
    // widest frame, widest box, one row high
    configure(11'd2047, 11'd2047, 11'd127, 11'd1);
    repeat (100) send_pixel(PIXEL_W'($urandom));
    // one column, tallest box, whole frame
    configure(11'd1, 11'd70, 11'd1, 11'h7C0);
    repeat (70) send_pixel(pick_pixel(PIX_RAILS, '0));
  endtask

  // random settings, mostly whole frames with the odd broken one
  task automatic test_random_frames(input int goal);
    logic [10:0] w, h, fw, fh;
    bit [3:0] pick;
    int unsigned span, count;
    pixel_style_t style;
    logic [PIXEL_W-1:0] level;
    while (pixels_sent < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        w  = 11'($urandom);
        h  = 11'($urandom);
        fw = 11'($urandom);
        fh = 11'($urandom);
      end else begin
        w  = 11'($urandom_range(1, 12));
        h  = 11'($urandom_range(1, 8));
        fw = 11'($urandom_range(1, w + 1));
        fh = 11'($urandom_range(1, h + 1));
      end
      pick = ($urandom_range(0, 4) == 0) ? 4'(1 << $urandom_range(0, 3)) : 4'hF;
      configure(w, h, fw, fh, pick);

      span = clamp_dim(reg_img_w, DEF_MAX_WIDTH) * clamp_dim(reg_img_h, DEF_MAX_HEIGHT);
      if (span > 300)
        count = $urandom_range(20, 150);
      else
        count = $urandom_range(1, 3) * span +
                (($urandom_range(0, 3) == 0) ? $urandom_range(1, span) : 0);
      style = pixel_style_t'($urandom_range(0, 3));
      level = PIXEL_W'($urandom);
      repeat (count) send_pixel(pick_pixel(style, level));
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_predictor();
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    test_full_scale_box();
    test_zero_map();
    test_tied_peaks();
    test_box_exceeds_frame();
    test_register_clamping();
    test_dimension_extremes();
    test_random_frames(900);

    // final stretch at full rate on both sides
    idle_gaps    = 1'b0;
    stall_bursts = 1'b0;
    test_random_frames(1000);

    wait_drained();
    repeat (20) @(negedge clk);

    $display("sent %0d map values under %0d register settings, checked %0d result items",
             pixels_sent, settings_used, results_seen);
    $display("covered full-scale, zero and tied maps, oversized boxes and clamped sizes");
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
